[rtl/core/vgns_pkg.sv]
package vgns_pkg;

    // Item kinds on the input channel
    typedef enum logic [1:0] {
        MODE_VOXEL = 2'd0,
        MODE_COEF  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_SIZE_X = 2'd0;
    localparam logic [1:0] CFG_SIZE_Y = 2'd1;
    localparam logic [1:0] CFG_SIZE_Z = 2'd2;
    localparam logic [5:0] SIZE_RESET = 6'd32;

    // Coefficient store layout
    localparam int NUM_COEF = 18;
    localparam int C_MAT    = 0;   // 3x3 row-major, 0..8
    localparam int C_OFF_X  = 9;
    localparam int C_OFF_Y  = 10;
    localparam int C_OFF_Z  = 11;
    localparam int C_COS    = 12;
    localparam int C_SIN    = 13;
    localparam int C_B00    = 14;
    localparam int C_B01    = 15;
    localparam int C_B10    = 16;
    localparam int C_B11    = 17;

    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] prod_t;

    // Full-precision product of two Q16.16 values, in Q32.32
    function automatic prod_t q_mul_raw(input q_t a, input q_t b);
        return 64'(a) * 64'(b);
    endfunction

    // Product back to Q16.16: floor shift by 16, then saturate
    function automatic q_t q_scale(input prod_t p);
        logic signed [47:0] v;
        v = p[63:16];
        if (v > 48'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -48'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic q_t q_sat33(input logic signed [32:0] s);
        if (s[32] != s[31])
            return s[32] ? 32'sh80000000 : 32'sh7fffffff;
        else
            return s[31:0];
    endfunction

    function automatic q_t q_add(input q_t a, input q_t b);
        return q_sat33(33'(a) + 33'(b));
    endfunction

    function automatic q_t q_sub(input q_t a, input q_t b);
        return q_sat33(33'(a) - 33'(b));
    endfunction

endpackage

[rtl/core/volume_grid_nearest_sampler_unit.sv]
// Nearest-neighbor sampler of a 3D voxel grid in Q16.16. The block takes one item per
// cycle while item_stall is low and returns query results in order; voxel loads flow
// down the same pipeline and write the voxel memory at the stage where queries read it,
// so loads and queries act in order. A coefficient load is held off until every item
// ahead of it has left the pipeline, then it writes at once. Load items and mode 3 give
// no result. The configuration port is always ready; the user must write the size
// registers only while the block is idle, as the block itself does not enforce it.
module volume_grid_nearest_sampler_unit #(
    parameter int GRID_X = 32,
    parameter int GRID_Y = 32,
    parameter int GRID_Z = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // item channel
    input  logic                item_valid,
    output logic                item_stall,
    input  logic [1:0]          mode,
    input  vgns_pkg::q_t        coord_x,
    input  vgns_pkg::q_t        coord_y,
    input  vgns_pkg::q_t        coord_z,
    input  logic [14:0]         voxel_address,
    input  logic [4:0]          coeff_index,
    input  vgns_pkg::q_t        load_value,
    input  logic                apply_lattice,
    input  logic                apply_rotation,
    // result channel
    output logic                result_valid,
    input  logic                result_stall,
    output vgns_pkg::q_t        sample_value,
    output logic                inside_res,
    // configuration channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [5:0]          cfg_data
);
    import vgns_pkg::*;

    localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCAR  = 9;   // stages that carry item kind and load data
    localparam logic [8:0]  GX9 = 9'(GRID_X);
    localparam logic [8:0]  GY9 = 9'(GRID_Y);
    localparam logic [8:0]  GZ9 = 9'(GRID_Z);
    localparam logic [31:0] DEPTH32 = 32'(DEPTH);
    localparam logic [31:0] STRIDE_Y = 32'(GRID_X);
    localparam logic [31:0] STRIDE_Z = 32'(GRID_X * GRID_Y);

    // Configuration and coefficient state
    logic [5:0] size_x_reg, size_y_reg, size_z_reg;
    q_t         coef_reg [NUM_COEF];

    // Carried along the pipeline: item kind and voxel load data
    logic        q_vld_reg  [NCAR];
    logic        w_vld_reg  [NCAR];
    logic [14:0] waddr_reg  [NCAR];
    q_t          wdata_reg  [NCAR];

    // Per-stage payload
    prod_t s1_p_reg [4];
    q_t    s1_x_reg, s1_y_reg, s1_z_reg;
    logic  s1_lat_reg, s1_rot_reg;
    q_t    s2_x_reg, s2_y_reg, s2_z_reg;
    logic  s2_rot_reg;
    prod_t s3_p_reg [4];
    q_t    s3_x_reg, s3_y_reg, s3_z_reg;
    logic  s3_rot_reg;
    q_t    s4_x_reg, s4_y_reg, s4_z_reg;
    q_t    s5_b_reg [3];
    prod_t s6_p_reg [9];
    q_t    s7_acc_reg [3];
    logic [16:0] s8_n_reg [3];
    logic  s8_in_reg;
    logic [AW-1:0] s9_addr_reg;
    logic  s9_in_reg;
    logic  out_vld_reg, out_in_reg;
    q_t    rd_reg;

    logic [31:0] vox_mem [DEPTH];

    logic adv;
    logic busy;
    logic accept;
    logic coef_wait;

    // Pipeline moves whenever the result register is free or being taken
    assign adv = !(out_vld_reg && result_stall);

    always_comb
    begin
        busy = out_vld_reg;
        for (int i = 0; i < NCAR; i++)
        begin
            busy = busy | q_vld_reg[i] | w_vld_reg[i];
        end
    end

    assign coef_wait  = item_valid && (mode == MODE_COEF) && busy;
    assign item_stall = !adv || coef_wait;
    assign accept     = item_valid && !item_stall;
    assign cfg_ready  = 1'b1;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SIZE_X: size_x_reg <= cfg_data;
                CFG_SIZE_Y: size_y_reg <= cfg_data;
                CFG_SIZE_Z: size_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Coefficient store, written only with the pipeline empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (accept && mode == MODE_COEF)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                if (coeff_index == 5'(i))
                    coef_reg[i] <= load_value;
            end
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCAR; i++)
            begin
                q_vld_reg[i] <= 1'b0;
                w_vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_vld_reg[0] <= accept && (mode == MODE_QUERY);
            w_vld_reg[0] <= accept && (mode == MODE_VOXEL)
                            && ({17'd0, voxel_address} < DEPTH32);
            for (int i = 1; i < NCAR; i++)
            begin
                q_vld_reg[i] <= q_vld_reg[i-1];
                w_vld_reg[i] <= w_vld_reg[i-1];
            end
            out_vld_reg <= q_vld_reg[NCAR-1];
        end
    end

    // Load data carry
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            waddr_reg[0] <= voxel_address;
            wdata_reg[0] <= load_value;
            for (int i = 1; i < NCAR; i++)
            begin
                waddr_reg[i] <= waddr_reg[i-1];
                wdata_reg[i] <= wdata_reg[i-1];
            end
        end
    end

    // Arithmetic stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // s1: lattice products
            s1_p_reg[0] <= q_mul_raw(coord_x, coef_reg[C_B00]);
            s1_p_reg[1] <= q_mul_raw(coord_y, coef_reg[C_B10]);
            s1_p_reg[2] <= q_mul_raw(coord_x, coef_reg[C_B01]);
            s1_p_reg[3] <= q_mul_raw(coord_y, coef_reg[C_B11]);
            s1_x_reg    <= coord_x;
            s1_y_reg    <= coord_y;
            s1_z_reg    <= coord_z;
            s1_lat_reg  <= apply_lattice;
            s1_rot_reg  <= apply_rotation;

            // s2: lattice sums
            if (s1_lat_reg)
            begin
                s2_x_reg <= q_add(q_scale(s1_p_reg[0]), q_scale(s1_p_reg[1]));
                s2_y_reg <= q_add(q_scale(s1_p_reg[2]), q_scale(s1_p_reg[3]));
            end
            else
            begin
                s2_x_reg <= s1_x_reg;
                s2_y_reg <= s1_y_reg;
            end
            s2_z_reg   <= s1_z_reg;
            s2_rot_reg <= s1_rot_reg;

            // s3: rotation products
            s3_p_reg[0] <= q_mul_raw(s2_x_reg, coef_reg[C_COS]);
            s3_p_reg[1] <= q_mul_raw(s2_y_reg, coef_reg[C_SIN]);
            s3_p_reg[2] <= q_mul_raw(s2_x_reg, coef_reg[C_SIN]);
            s3_p_reg[3] <= q_mul_raw(s2_y_reg, coef_reg[C_COS]);
            s3_x_reg    <= s2_x_reg;
            s3_y_reg    <= s2_y_reg;
            s3_z_reg    <= s2_z_reg;
            s3_rot_reg  <= s2_rot_reg;

            // s4: rotation sums
            if (s3_rot_reg)
            begin
                s4_x_reg <= q_sub(q_scale(s3_p_reg[0]), q_scale(s3_p_reg[1]));
                s4_y_reg <= q_add(q_scale(s3_p_reg[2]), q_scale(s3_p_reg[3]));
            end
            else
            begin
                s4_x_reg <= s3_x_reg;
                s4_y_reg <= s3_y_reg;
            end
            s4_z_reg <= s3_z_reg;

            // s5: remove offset
            s5_b_reg[0] <= q_sub(s4_x_reg, coef_reg[C_OFF_X]);
            s5_b_reg[1] <= q_sub(s4_y_reg, coef_reg[C_OFF_Y]);
            s5_b_reg[2] <= q_sub(s4_z_reg, coef_reg[C_OFF_Z]);

            // s6: matrix products
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    s6_p_reg[3*r+c] <= q_mul_raw(coef_reg[C_MAT + 3*r + c], s5_b_reg[c]);
                end
            end

            // s7: row sums, saturated in order
            for (int r = 0; r < 3; r++)
            begin
                s7_acc_reg[r] <= q_add(q_add(q_scale(s6_p_reg[3*r]),
                                             q_scale(s6_p_reg[3*r+1])),
                                       q_scale(s6_p_reg[3*r+2]));
            end
        end
    end

    // s8: round half away from zero and bound check
    logic [8:0]  eff_sz [3];
    logic [16:0] n_mag  [3];
    logic        row_in [3];

    always_comb
    begin
        logic        neg;
        logic [32:0] mag;
        logic [32:0] rsum;
        eff_sz[0] = (9'(size_x_reg) > GX9) ? GX9 : 9'(size_x_reg);
        eff_sz[1] = (9'(size_y_reg) > GY9) ? GY9 : 9'(size_y_reg);
        eff_sz[2] = (9'(size_z_reg) > GZ9) ? GZ9 : 9'(size_z_reg);
        for (int r = 0; r < 3; r++)
        begin
            neg      = s7_acc_reg[r][31];
            mag      = neg ? (33'd0 - 33'(s7_acc_reg[r])) : 33'(s7_acc_reg[r]);
            rsum     = mag + 33'd32768;
            n_mag[r] = rsum[32:16];
            row_in[r] = (!neg || n_mag[r] == 17'd0) && (n_mag[r] < 17'(eff_sz[r]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s8_n_reg[r] <= n_mag[r];
            end
            s8_in_reg <= row_in[0] && row_in[1] && row_in[2];

            // s9: linear voxel address
            s9_addr_reg <= AW'(32'(s8_n_reg[0]) + STRIDE_Y * 32'(s8_n_reg[1])
                               + STRIDE_Z * 32'(s8_n_reg[2]));
            s9_in_reg   <= s8_in_reg;

            out_in_reg  <= s9_in_reg;
        end
    end

    // Voxel memory: loads and queries meet it in item order
    logic [AW-1:0] mem_addr;
    assign mem_addr = w_vld_reg[NCAR-1] ? AW'(waddr_reg[NCAR-1]) : s9_addr_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (w_vld_reg[NCAR-1])
                vox_mem[mem_addr] <= wdata_reg[NCAR-1];
            rd_reg <= vox_mem[mem_addr];
        end
    end

    // Result
    assign result_valid = out_vld_reg;
    assign inside_res   = out_in_reg;
    assign sample_value = out_in_reg ? rd_reg : '0;

endmodule

[tb/sv/testbench.sv]
module testbench;
    import vgns_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic [1:0]  mode;
    q_t          coord_x;
    q_t          coord_y;
    q_t          coord_z;
    logic [14:0] voxel_address;
    logic [4:0]  coeff_index;
    q_t          load_value;
    logic        apply_lattice;
    logic        apply_rotation;
    logic        result_valid;
    logic        result_stall;
    q_t          sample_value;
    logic        inside_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [5:0]  cfg_data;

    volume_grid_nearest_sampler_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .mode(mode),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .voxel_address(voxel_address), .coeff_index(coeff_index),
        .load_value(load_value), .apply_lattice(apply_lattice),
        .apply_rotation(apply_rotation),
        .result_valid(result_valid), .result_stall(result_stall),
        .sample_value(sample_value), .inside_res(inside_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Model state
    logic [31:0] voxel_mem [0:32767];
    bit          voxel_known [0:32767];
    q_t          coef_mem [0:NUM_COEF-1];
    logic [5:0]  grid_size [0:2];

    // Expected samples
    q_t expected_value_q [$];
    bit expected_inside_q [$];

    int error_count;
    int query_count;
    int inside_count;
    int item_count;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_results;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Fixed-point helpers, written from the arithmetic rules
    function automatic q_t sat_q(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return q_t'(v);
    endfunction

    function automatic q_t fx_mul(input q_t a, input q_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat_q(p >>> 16);
    endfunction

    function automatic q_t fx_add(input q_t a, input q_t b);
        return sat_q(longint'(a) + longint'(b));
    endfunction

    function automatic q_t fx_sub(input q_t a, input q_t b);
        return sat_q(longint'(a) - longint'(b));
    endfunction

    // Round half away from zero to integer
    function automatic longint round_index(input q_t v);
        longint m;
        m = longint'(v);
        if (m >= 0)
            return (m + 32768) / 65536;
        return -((-m + 32768) / 65536);
    endfunction

    // Index of a query point, -1 when outside
    function automatic int query_address(input q_t x0, input q_t y0, input q_t z0,
                                         input bit lat, input bit rot);
        q_t x, y, t, acc;
        q_t d [0:2];
        longint n [0:2];
        int lim;
        x = x0;
        y = y0;
        if (lat)
        begin
            t = fx_add(fx_mul(x, coef_mem[C_B00]), fx_mul(y, coef_mem[C_B10]));
            y = fx_add(fx_mul(x, coef_mem[C_B01]), fx_mul(y, coef_mem[C_B11]));
            x = t;
        end
        if (rot)
        begin
            t = fx_sub(fx_mul(x, coef_mem[C_COS]), fx_mul(y, coef_mem[C_SIN]));
            y = fx_add(fx_mul(x, coef_mem[C_SIN]), fx_mul(y, coef_mem[C_COS]));
            x = t;
        end
        d[0] = fx_sub(x, coef_mem[C_OFF_X]);
        d[1] = fx_sub(y, coef_mem[C_OFF_Y]);
        d[2] = fx_sub(z0, coef_mem[C_OFF_Z]);
        for (int r = 0; r < 3; r++)
        begin
            acc = fx_mul(coef_mem[3 * r], d[0]);
            acc = fx_add(acc, fx_mul(coef_mem[3 * r + 1], d[1]));
            acc = fx_add(acc, fx_mul(coef_mem[3 * r + 2], d[2]));
            n[r] = round_index(acc);
            lim = (grid_size[r] > 32) ? 32 : grid_size[r];
            if (n[r] < 0 || n[r] >= lim)
                return -1;
        end
        return int'(n[0] + 32 * n[1] + 1024 * n[2]);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("ERROR %0t: %s got %0h expected %0h", $time, what, got, want);
        error_count++;
    endtask

    // Send one item; waits for acceptance, returns at the next falling edge
    task automatic send_item(input mode_t m, input q_t x, input q_t y, input q_t z,
                             input logic [14:0] adr, input logic [4:0] ci, input q_t val,
                             input bit lat, input bit rot);
        int a;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        coord_x <= x;
        coord_y <= y;
        coord_z <= z;
        voxel_address <= adr;
        coeff_index <= ci;
        load_value <= val;
        apply_lattice <= lat;
        apply_rotation <= rot;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        item_count++;
        case (m)
            MODE_VOXEL:
            begin
                voxel_mem[adr] = val;
                voxel_known[adr] = 1'b1;
            end
            MODE_COEF:
                if (ci < NUM_COEF)
                    coef_mem[ci] = val;
            MODE_QUERY:
            begin
                a = query_address(x, y, z, lat, rot);
                query_count++;
                expected_value_q.insert(expected_value_q.size(),
                                        a >= 0 ? q_t'(voxel_mem[a]) : q_t'(0));
                expected_inside_q.insert(expected_inside_q.size(), a >= 0);
                if (a >= 0)
                    inside_count++;
            end
            default:
                ;
        endcase
        @(negedge clk);
    endtask

    // Query only points that are outside or hit a written voxel
    task automatic send_query(input q_t x, input q_t y, input q_t z, input bit lat,
                              input bit rot);
        int a;
        a = query_address(x, y, z, lat, rot);
        if (a < 0 || voxel_known[a])
            send_item(MODE_QUERY, x, y, z, 0, 0, 0, lat, rot);
    endtask

    task automatic write_size(input logic [1:0] idx, input logic [5:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        grid_size[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        int n;
        n = 0;
        item_valid <= 1'b0;
        while (expected_value_q.size() != 0 && n < 200000)
        begin
            @(negedge clk);
            n++;
        end
        repeat (30)
            @(negedge clk);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_value_q.size() == 0)
            begin
                report_mismatch("unexpected sample", sample_value, 0);
            end
            else
            begin
                if (sample_value !== expected_value_q[0])
                    report_mismatch("sample_value", sample_value, expected_value_q[0]);
                if (inside_res !== expected_inside_q[0])
                    report_mismatch("inside_res", inside_res, expected_inside_q[0]);
                void'(expected_value_q.pop_front());
                void'(expected_inside_q.pop_front());
            end
        end
    end

    // Receiver stall
    always @(negedge clk)
        result_stall <= hold_results || ($urandom_range(99) < recv_stall_pct);

    function automatic q_t rand_q;
        case ($urandom_range(4))
            0: return q_t'($urandom);
            1: return q_t'(32'sh80000000 + $urandom_range(1));
            2: return q_t'(32'sh7fffffff - $urandom_range(1));
            default: return q_t'($urandom_range(4 * 65536));
        endcase
    endfunction

    // Identity matrix, zero offset and unit basis/rotation
    task automatic load_identity;
        for (int i = 0; i < NUM_COEF; i++)
            send_item(MODE_COEF, 0, 0, 0, 0, i[4:0],
                      (i == 0 || i == 4 || i == 8 || i == C_COS || i == C_B00 ||
                       i == C_B11) ? q_t'(32'sh10000) : q_t'(0), 0, 0);
    endtask

    // Small corner cube of voxels that random queries land in
    task automatic fill_voxels;
        for (int k = 0; k < 5; k++)
            for (int j = 0; j < 5; j++)
                for (int i = 0; i < 5; i++)
                begin
                    voxel_mem[i + 32 * j + 1024 * k] = $urandom;
                    voxel_known[i + 32 * j + 1024 * k] = 1'b1;
                end
    endtask

    task automatic test_directed;
        load_identity();
        // Corners and edges of the grid, rounding at half
        send_item(MODE_VOXEL, 0, 0, 0, 15'd0, 0, 32'sh80000000, 0, 0);
        send_item(MODE_VOXEL, 0, 0, 0, 15'd32767, 0, 32'sh7fffffff, 0, 0);
        send_query(0, 0, 0, 0, 0);
        send_query(32'sh7fff, 32'sh7fff, 32'sh7fff, 0, 0);
        send_query(-32'sh8000, 0, 0, 0, 0);
        send_query(-32'sh7fff, 0, 0, 0, 0);
        send_query(32'sh1f0000, 32'sh1f0000, 32'sh1f0000, 1, 1);
        send_query(32'sh1f8000, 0, 0, 0, 0);
        send_query(32'sh7fffffff, 32'sh80000000, 0, 0, 0);
        // Mode 3 and out of range coefficient index are ignored
        send_item(MODE_NONE, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(MODE_COEF, 0, 0, 0, 0, 5'd31, 32'sh12345678, 0, 0);
        send_item(MODE_COEF, 0, 0, 0, 0, 5'd18, 32'sh12345678, 0, 0);
        send_query(0, 0, 0, 1, 1);
        // Saturating coefficients
        send_item(MODE_COEF, 0, 0, 0, 0, 5'(C_B00), 32'sh7fffffff, 0, 0);
        send_item(MODE_COEF, 0, 0, 0, 0, 5'(C_SIN), 32'sh80000000, 0, 0);
        send_query(32'sh7fffffff, 32'sh80000000, 0, 1, 1);
        send_query(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 1, 0);
        drain();
    endtask

    task automatic test_random(input int n);
        int c;
        q_t v;
        for (int i = 0; i < n; i++)
        begin
            c = $urandom_range(99);
            if (c < 8)
            begin
                v = ($urandom_range(3) == 0) ? rand_q() : q_t'($urandom_range(131072) - 65536);
                send_item(MODE_COEF, rand_q(), rand_q(), rand_q(), 15'($urandom),
                          5'($urandom_range(31)), v, 1'($urandom), 1'($urandom));
            end
            else if (c < 20)
                send_item(MODE_VOXEL, rand_q(), rand_q(), rand_q(), 15'($urandom),
                          5'($urandom), q_t'($urandom), 1'($urandom), 1'($urandom));
            else if (c < 23)
                send_item(MODE_NONE, rand_q(), rand_q(), rand_q(), 15'($urandom),
                          5'($urandom), q_t'($urandom), 1'($urandom), 1'($urandom));
            else
                send_query(rand_q(), rand_q(), rand_q(), 1'($urandom), 1'($urandom));
        end
    endtask

    // Make all voxels in the loaded set known to the block
    task automatic load_known_voxels(input int step);
        for (int a = 0; a < 32768; a += step)
            if (voxel_known[a])
                send_item(MODE_VOXEL, 0, 0, 0, a[14:0], 0, voxel_mem[a], 0, 0);
    endtask

    task automatic test_sizes;
        logic [5:0] s [0:2];
        for (int p = 0; p < 4; p++)
        begin
            drain();
            for (int r = 0; r < 3; r++)
            begin
                s[r] = (p == 0) ? 6'd0 : (p == 1) ? 6'd63 : (p == 2) ? 6'd1 : 6'($urandom);
                write_size(r[1:0], s[r]);
            end
            test_random(40);
        end
        drain();
        write_size(CFG_SIZE_X, SIZE_RESET);
        write_size(CFG_SIZE_Y, SIZE_RESET);
        write_size(CFG_SIZE_Z, SIZE_RESET);
    endtask

    task automatic test_backpressure;
        hold_results = 1'b1;
        fork
            begin
                for (int i = 0; i < 40; i++)
                    send_query(q_t'((i % 5) * 65536), 0, 0, 0, 0);
            end
            begin
                repeat (300)
                    @(negedge clk);
                hold_results = 1'b0;
            end
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        mode = MODE_NONE;
        coord_x = 0;
        coord_y = 0;
        coord_z = 0;
        voxel_address = 0;
        coeff_index = 0;
        load_value = 0;
        apply_lattice = 0;
        apply_rotation = 0;
        result_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SIZE_X;
        cfg_data = SIZE_RESET;
        hold_results = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        error_count = 0;
        query_count = 0;
        inside_count = 0;
        item_count = 0;
        for (int i = 0; i < 32768; i++)
        begin
            voxel_mem[i] = 0;
            voxel_known[i] = 1'b0;
        end
        for (int i = 0; i < NUM_COEF; i++)
            coef_mem[i] = 0;
        for (int i = 0; i < 3; i++)
            grid_size[i] = SIZE_RESET;
        repeat (10)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        fill_voxels();
        load_known_voxels(1);
        load_identity();
        test_backpressure();

        // Idle phases: none, sender, receiver, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 79) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 79) : 0;
            test_random(80);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_sizes();
        drain();

        $display("Ran %0d items: %0d queries, %0d inside the grid", item_count,
                 query_count, inside_count);
        $display("Covered coefficient loads, size extremes, idle phases and backpressure");
        if (error_count == 0 && expected_value_q.size() == 0)
            $display("volume_grid_nearest_sampler_unit: match");
        else
            $display("volume_grid_nearest_sampler_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("volume_grid_nearest_sampler_unit: mismatch");
        $finish;
    end

endmodule
